// File: design/lat_pkg.sv
package lat_pkg;

  localparam int RowW       = 64;
  localparam int ColW       = 7;
  localparam int GenW       = 16;
  localparam int IdxW       = 6;
  localparam int RowCntW    = 7;
  localparam int CfgIdxW    = 8;
  localparam int CfgDataW   = 16;
  localparam int OutDataW   = 72;
  localparam int DefMaxRows = 64;
  localparam int DefMaxCols = 64;

  localparam logic [CfgIdxW-1:0] CfgColumnCount     = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgGenerationCount = 8'd1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_EVOLVE,
    ST_EMIT
  } lat_state_e;

  typedef struct packed {
    logic            wr_en;
    logic [IdxW-1:0] wr_idx;
    logic            shift;
    logic [IdxW-1:0] tail_idx;
  } cell_ctrl_t;

endpackage

// File: design/lat_cell.sv
module lat_cell #(
  parameter int Index = 0
) (
  input  logic                     clk_i,
  input  lat_pkg::cell_ctrl_t      ctrl_i,
  input  logic [lat_pkg::RowW-1:0] wr_row_i,
  input  logic [lat_pkg::RowW-1:0] next_row_i,
  input  logic [lat_pkg::RowW-1:0] tail_row_i,
  output logic [lat_pkg::RowW-1:0] row_o
);

  localparam logic [lat_pkg::IdxW-1:0] MyIdx = lat_pkg::IdxW'(Index);

  logic [lat_pkg::RowW-1:0] row_q;
  logic [lat_pkg::RowW-1:0] row_d;

  always_comb begin
    row_d = row_q;
    if (ctrl_i.wr_en && (ctrl_i.wr_idx == MyIdx)) begin
      row_d = wr_row_i;
    end else if (ctrl_i.shift) begin
      // the tail of the ring takes the freshly computed row
      row_d = (ctrl_i.tail_idx == MyIdx) ? tail_row_i : next_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  assign row_o = row_q;

endmodule

// File: design/lat_rule.sv
module lat_rule (
  input  logic [lat_pkg::RowW-1:0] prev_i,
  input  logic [lat_pkg::RowW-1:0] cur_i,
  input  logic [lat_pkg::RowW-1:0] nxt_i,
  input  logic [lat_pkg::ColW-1:0] col_i,
  input  logic [lat_pkg::RowW-1:0] mask_i,
  output logic [lat_pkg::RowW-1:0] row_o
);

  localparam int W = lat_pkg::RowW;

  logic [lat_pkg::IdxW-1:0] cm1;
  logic [W-1:0] pl, pr, cl, cr, nl, nr;
  logic [W-1:0] row_raw;

  assign cm1 = lat_pkg::IdxW'(col_i - lat_pkg::ColW'(1));

  for (genvar j = 0; j < W; j++) begin : g_col
    logic [3:0] total;
    if (j == 0) begin : g_first
      assign pl[j] = prev_i[cm1];
      assign cl[j] = cur_i[cm1];
      assign nl[j] = nxt_i[cm1];
    end else begin : g_rest
      assign pl[j] = prev_i[j-1];
      assign cl[j] = cur_i[j-1];
      assign nl[j] = nxt_i[j-1];
    end
    // wrap at the column count
    assign pr[j] = (cm1 == lat_pkg::IdxW'(j)) ? prev_i[0] : prev_i[(j+1)%W];
    assign cr[j] = (cm1 == lat_pkg::IdxW'(j)) ? cur_i[0]  : cur_i[(j+1)%W];
    assign nr[j] = (cm1 == lat_pkg::IdxW'(j)) ? nxt_i[0]  : nxt_i[(j+1)%W];
    // total includes the cell itself: any cell lives on 3, a live cell also on 4
    assign total = 4'($countones({pl[j], prev_i[j], pr[j], cl[j], cur_i[j], cr[j],
                                  nl[j], nxt_i[j], nr[j]}));
    assign row_raw[j] = (total == 4'd3) || (cur_i[j] && (total == 4'd4));
  end

  assign row_o = row_raw & mask_i;

endmodule

// File: design/life_automaton_toroidal.sv
// Toroidal B3/S23 life engine. Rows arrive one per transaction, the tlast
// row (or row MAX_ROWS) closing a grid of r rows. The rows then sit in a ring of r cells that
// rotates one step a cycle past a single rule unit, one full turn per generation, and
// evolution runs for up to generation_count generations, ending early after a generation that
// leaves the grid unchanged. The grid is then sent out row by row, row index in tdata and the
// last row on tlast. No input is taken from the closing row until the last result has been
// loaded into the output register.
module life_automaton_toroidal #(
  parameter int MAX_ROWS = lat_pkg::DefMaxRows,
  parameter int MAX_COLS = lat_pkg::DefMaxCols
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lat_pkg::RowW-1:0]      s_axis_tdata,  // row_cells
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lat_pkg::OutDataW-1:0]  m_axis_tdata,  // out_row_cells, out_row_number, pad
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lat_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lat_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int W = lat_pkg::RowW;

  lat_pkg::lat_state_e            state_q, state_d;
  logic [lat_pkg::RowCntW-1:0]    rows_q, rows_d;
  logic [lat_pkg::IdxW-1:0]       r_last_q, r_last_d;
  logic [lat_pkg::IdxW-1:0]       step_q, step_d;
  logic [lat_pkg::GenW-1:0]       gen_q, gen_d;
  logic                           changed_q, changed_d;
  logic [lat_pkg::ColW-1:0]       col_q, col_d;
  logic [lat_pkg::GenW-1:0]       gen_cfg_q, gen_cfg_d;
  logic                           m_valid_q, m_valid_d;
  logic [W-1:0]                   prev_q, prev_d;
  logic [W-1:0]                   first_q, first_d;
  logic [W-1:0]                   out_row_q;
  logic [lat_pkg::IdxW-1:0]       out_num_q;
  logic                           out_last_q;
  logic                           out_load;
  logic                           changed_now;

  lat_pkg::cell_ctrl_t            cell_ctrl;
  logic [W-1:0]                   cell_row [MAX_ROWS];
  logic [W-1:0]                   head_row, second_row, nxt_row, rule_row;
  logic [W-1:0]                   col_mask;
  logic [W-1:0]                   load_row;
  logic [lat_pkg::ColW-1:0]       col_cfg;

  for (genvar j = 0; j < W; j++) begin : g_mask
    assign col_mask[j] = (lat_pkg::ColW'(j) < col_q);
  end

  assign load_row = s_axis_tdata & col_mask;

  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
    logic [W-1:0] next_in;
    if (k < MAX_ROWS - 1) begin : g_link
      assign next_in = cell_row[k+1];
    end else begin : g_end
      assign next_in = '0;
    end
    lat_cell #(
      .Index(k)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .wr_row_i  (load_row),
      .next_row_i(next_in),
      .tail_row_i(rule_row),
      .row_o     (cell_row[k])
    );
  end

  assign head_row = cell_row[0];
  if (MAX_ROWS > 1) begin : g_second
    assign second_row = cell_row[1];
  end else begin : g_single
    assign second_row = cell_row[0];
  end

  // the row after the last one is old row 0, saved at the first step
  assign nxt_row = (step_q != r_last_q) ? second_row :
                   (step_q == '0)       ? head_row   : first_q;

  lat_rule u_rule (
    .prev_i(prev_q),
    .cur_i (head_row),
    .nxt_i (nxt_row),
    .col_i (col_q),
    .mask_i(col_mask),
    .row_o (rule_row)
  );

  // column count clamped to 1..MAX_COLS
  always_comb begin
    col_cfg = cfg_data_i[lat_pkg::ColW-1:0];
    if (col_cfg == '0) begin
      col_cfg = lat_pkg::ColW'(1);
    end else if (col_cfg > lat_pkg::ColW'(MAX_COLS)) begin
      col_cfg = lat_pkg::ColW'(MAX_COLS);
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    col_d     = col_q;
    gen_cfg_d = gen_cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        lat_pkg::CfgColumnCount:     col_d     = col_cfg;
        lat_pkg::CfgGenerationCount: gen_cfg_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    r_last_d    = r_last_q;
    step_d      = step_q;
    gen_d       = gen_q;
    changed_d   = changed_q;
    prev_d      = prev_q;
    first_d     = first_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    out_load    = 1'b0;
    changed_now = changed_q || (rule_row != head_row);
    s_axis_tready      = 1'b0;
    cell_ctrl.wr_en    = 1'b0;
    cell_ctrl.wr_idx   = rows_q[lat_pkg::IdxW-1:0];
    cell_ctrl.shift    = 1'b0;
    cell_ctrl.tail_idx = r_last_q;
    case (state_q)
      lat_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cell_ctrl.wr_en = 1'b1;
          if (s_axis_tlast || (rows_q == lat_pkg::RowCntW'(MAX_ROWS - 1))) begin
            r_last_d  = rows_q[lat_pkg::IdxW-1:0];
            rows_d    = '0;
            prev_d    = load_row;
            step_d    = '0;
            gen_d     = '0;
            changed_d = 1'b0;
            state_d   = (gen_cfg_q == '0) ? lat_pkg::ST_EMIT : lat_pkg::ST_EVOLVE;
          end else begin
            rows_d = rows_q + lat_pkg::RowCntW'(1);
          end
        end
      end
      lat_pkg::ST_EVOLVE: begin
        cell_ctrl.shift = 1'b1;
        if (step_q == '0) begin
          first_d = head_row;
        end
        if (step_q == r_last_q) begin
          prev_d    = rule_row;
          step_d    = '0;
          changed_d = 1'b0;
          gen_d     = gen_q + lat_pkg::GenW'(1);
          if (!changed_now || (gen_q + lat_pkg::GenW'(1) == gen_cfg_q)) begin
            state_d = lat_pkg::ST_EMIT;
          end
        end else begin
          prev_d    = head_row;
          step_d    = step_q + lat_pkg::IdxW'(1);
          changed_d = changed_now;
        end
      end
      lat_pkg::ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load        = 1'b1;
          m_valid_d       = 1'b1;
          cell_ctrl.shift = 1'b1;
          if (step_q == r_last_q) begin
            step_d  = '0;
            state_d = lat_pkg::ST_LOAD;
          end else begin
            step_d = step_q + lat_pkg::IdxW'(1);
          end
        end
      end
      default: begin
        state_d = lat_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lat_pkg::ST_LOAD;
      rows_q    <= '0;
      r_last_q  <= '0;
      step_q    <= '0;
      gen_q     <= '0;
      changed_q <= 1'b0;
      col_q     <= (MAX_COLS < 64) ? lat_pkg::ColW'(MAX_COLS) : lat_pkg::ColW'(64);
      gen_cfg_q <= lat_pkg::GenW'(1);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rows_q    <= rows_d;
      r_last_q  <= r_last_d;
      step_q    <= step_d;
      gen_q     <= gen_d;
      changed_q <= changed_d;
      col_q     <= col_d;
      gen_cfg_q <= gen_cfg_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q  <= prev_d;
    first_q <= first_d;
    if (out_load) begin
      out_row_q  <= head_row;
      out_num_q  <= step_q;
      out_last_q <= (step_q == r_last_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(lat_pkg::OutDataW - W - lat_pkg::IdxW)'(0), out_num_q, out_row_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// File: design/lat_checker.sv
module lat_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [lat_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

  // rows leave in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (!m_axis_tvalid ||
       (m_axis_tdata[69:64] == $past(m_axis_tdata[69:64]) + 6'd1)))
    else $error("row number out of sequence");

  // no input taken while a grid is still going out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("input accepted during output");

  // padding bits stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[71:70] == 2'b00))
    else $error("padding bits set");

endmodule

bind life_automaton_toroidal lat_checker u_lat_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
